@@ src/lcd_mode_timing_controller_defines.svh @@
// Assertion macros shared by the LCD timing controller checker.
`ifndef LCD_MODE_TIMING_CONTROLLER_DEFINES_SVH
`define LCD_MODE_TIMING_CONTROLLER_DEFINES_SVH

// Antecedent true this cycle implies consequent true this cycle.
`define LMTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmtc check failed");

// Antecedent true this cycle implies consequent true next cycle.
`define LMTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmtc check failed");

`endif

@@ src/lmtc_pkg.sv @@
// Shared constants for the LCD mode timing controller.
`default_nettype none
package lmtc_pkg;

    // Mode codes
    localparam logic [1:0] MODE_LINE_GAP  = 2'd0;
    localparam logic [1:0] MODE_FRAME_GAP = 2'd1;
    localparam logic [1:0] MODE_OAM       = 2'd2;
    localparam logic [1:0] MODE_XFER      = 2'd3;

    // Mode lengths in ticks
    localparam int TICKS_OAM    = 80;
    localparam int TICKS_XFER   = 172;
    localparam int TICKS_HBLANK = 204;
    localparam int TICKS_VBLANK = 4560;
    localparam int TICKS_LINE   = 456;
    localparam int VBLANK_LINES = TICKS_VBLANK / TICKS_LINE;

    localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;

    // Budget saturation limits (14-bit signed)
    localparam int BUDGET_MIN = -8192;
    localparam int BUDGET_MAX = 8191;

    // Configuration register indexes
    localparam logic CFG_IDX_ENABLES = 1'b0;
    localparam logic CFG_IDX_COMPARE = 1'b1;

    // STAT enable bits
    localparam int EN_HBLANK = 0;
    localparam int EN_VBLANK = 1;
    localparam int EN_OAM    = 2;
    localparam int EN_MATCH  = 3;

endpackage
`default_nettype wire

@@ src/lcd_mode_timing_controller.sv @@
// LCD mode timing controller: mode, line and STAT sequencing per tick request.
//
//  channel   direction  payload                                  handshake
//  in        sink       elapsed_ticks[7:0]                       in_valid / in_ready
//  out       source     mode, line, match, stat, four pulses     out_valid / out_ready
//  cfg       sink       cfg_index[0], cfg_data[7:0]              cfg_valid / cfg_ready
//
// One request per cycle sustained while out_ready is high; a request passes the
// input register, then the state update and result register in one pass.
// Throughput is set by the state update loop (budget, line,
// v-blank sub-counter), all of which close in the compute cycle.
// Out stalls back up into the input register, then in_ready drops.
// cfg_ready is low while a request waits in the input register.
// rst_n is asynchronous; after reset: OAM search, budget 80, line 0, match set.
`default_nettype none
module lcd_mode_timing_controller (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // tick requests
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] elapsed_ticks,
    // results
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      lcd_mode,
    output logic [7:0]      current_line,
    output logic            line_match,
    output logic [6:0]      stat_byte,
    output logic            vblank_request,
    output logic            lcdc_request,
    output logic            render_strobe,
    output logic            swap_pulse,
    // configuration writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);
    import lmtc_pkg::*;

    localparam logic signed [15:0] BUDGET_MIN_W = 16'(BUDGET_MIN);
    localparam logic signed [15:0] BUDGET_MAX_W = 16'(BUDGET_MAX);

    // Input stage
    logic       in_valid_reg;
    logic [7:0] ticks_reg;

    // Sequencer state
    logic [1:0]         mode_reg,  mode_next;
    logic signed [13:0] budget_reg, budget_next;
    logic [7:0]         line_reg,  line_next;
    logic signed [9:0]  vlt_reg,   vlt_next;
    logic               match_reg, match_next;

    // Configuration
    logic [3:0] enables_reg;
    logic [7:0] compare_reg;

    // Result register
    logic       out_valid_reg;
    logic [1:0] mode_out_reg;
    logic [7:0] line_out_reg;
    logic       match_out_reg;
    logic [6:0] stat_out_reg;
    logic       vbl_out_reg, lcdc_out_reg, render_out_reg, swap_out_reg;

    // Step results
    logic vbl_req, lcdc_fire, render, swap;

    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    // writes only land between steps, never beside one
    assign cfg_ready = !in_valid_reg;

    // ---------------------------------------------------------------
    // One step of the sequencer, from the registered tick count.
    // ---------------------------------------------------------------
    always_comb
    begin
        logic signed [15:0] budget_ext;
        logic signed [15:0] ticks_ext;
        logic signed [15:0] dec;
        logic               dec_le0;
        logic signed [10:0] vlt_dec;
        logic signed [10:0] vlt_wrap;
        logic [7:0]         line_a;
        logic [7:0]         line_inc;
        logic signed [15:0] budget_sum;
        logic signed [15:0] vb_sum;
        logic signed [15:0] vb_abs;
        logic [12:0]        vb_mag;
        logic [12:0]        vb_sub;
        logic [12:0]        vb_rem;
        logic [9:0]         rem_pos;

        budget_ext = {{2{budget_reg[13]}}, budget_reg};
        ticks_ext  = {8'd0, ticks_reg};
        dec        = budget_ext - ticks_ext;
        dec_le0    = dec[15] || (dec == 16'sd0);

        mode_next  = mode_reg;
        line_next  = line_reg;
        vlt_next   = vlt_reg;
        match_next = match_reg;
        vbl_req    = 1'b0;
        lcdc_fire  = 1'b0;
        render     = 1'b0;
        swap       = 1'b0;
        budget_sum = dec;
        line_a     = line_reg;
        vlt_dec    = '0;
        vlt_wrap   = '0;

        // v-blank line sub-counter runs ahead of the mode change
        if (mode_reg == MODE_FRAME_GAP)
        begin
            vlt_dec = {vlt_reg[9], vlt_reg} - {3'd0, ticks_reg};
            if (vlt_dec[10] || (vlt_dec == 11'sd0))
            begin
                line_a     = line_reg + 8'd1;
                vlt_wrap   = vlt_dec + 11'(TICKS_LINE);
                vlt_next   = vlt_wrap[9:0];
                match_next = (line_a == compare_reg);
                if ((line_a == compare_reg) && enables_reg[EN_MATCH])
                    lcdc_fire = 1'b1;
            end
            else
            begin
                vlt_next = vlt_dec[9:0];
            end
            swap = dec_le0;
        end
        line_next = line_a;

        // Remainder of the v-blank budget modulo one line, truncating toward zero
        vb_sum = dec + 16'(TICKS_VBLANK);
        vb_abs = vb_sum[15] ? -vb_sum : vb_sum;
        vb_mag = vb_abs[12:0];
        vb_sub = '0;
        for (int k = 1; k <= VBLANK_LINES; k++)
        begin
            if (vb_mag >= 13'(k * TICKS_LINE))
                vb_sub = 13'(k * TICKS_LINE);
        end
        vb_rem  = vb_mag - vb_sub;
        rem_pos = vb_rem[9:0];

        // Next visible line, wrapping out of v-blank
        line_inc = line_a + 8'd1;
        if (line_inc >= FIRST_VBLANK_LINE)
            line_inc = 8'd0;

        if (dec_le0)
        begin
            unique case (mode_reg)
                MODE_OAM:
                begin
                    mode_next  = MODE_XFER;
                    budget_sum = dec + 16'(TICKS_XFER);
                end
                MODE_XFER:
                begin
                    mode_next  = MODE_LINE_GAP;
                    budget_sum = dec + 16'(TICKS_HBLANK);
                    render     = 1'b1;
                    if (enables_reg[EN_HBLANK])
                        lcdc_fire = 1'b1;
                end
                MODE_LINE_GAP, MODE_FRAME_GAP:
                begin
                    if ((mode_reg == MODE_LINE_GAP) && (line_reg == LAST_VISIBLE_LINE))
                    begin
                        mode_next  = MODE_FRAME_GAP;
                        budget_sum = vb_sum;
                        line_next  = FIRST_VBLANK_LINE;
                        match_next = (FIRST_VBLANK_LINE == compare_reg);
                        if ((FIRST_VBLANK_LINE == compare_reg) && enables_reg[EN_MATCH])
                            lcdc_fire = 1'b1;
                        vlt_next   = vb_sum[15] ? -rem_pos : rem_pos;
                        vbl_req    = 1'b1;
                        if (enables_reg[EN_VBLANK])
                            lcdc_fire = 1'b1;
                    end
                    else
                    begin
                        // new line: OAM search
                        mode_next  = MODE_OAM;
                        budget_sum = dec + 16'(TICKS_OAM);
                        line_next  = line_inc;
                        match_next = (line_inc == compare_reg);
                        if ((line_inc == compare_reg) && enables_reg[EN_MATCH])
                            lcdc_fire = 1'b1;
                        if (enables_reg[EN_OAM])
                            lcdc_fire = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        // Saturate the budget to its 14-bit range
        if (budget_sum < BUDGET_MIN_W)
            budget_next = 14'(BUDGET_MIN);
        else if (budget_sum > BUDGET_MAX_W)
            budget_next = 14'(BUDGET_MAX);
        else
            budget_next = budget_sum[13:0];
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ticks_reg <= elapsed_ticks;
    end

    // Sequencer state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OAM;
            budget_reg  <= 14'(TICKS_OAM);
            line_reg    <= 8'd0;
            vlt_reg     <= 10'sd0;
            match_reg   <= 1'b1;
            enables_reg <= 4'd0;
            compare_reg <= 8'd0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            budget_reg <= budget_next;
            line_reg   <= line_next;
            vlt_reg    <= vlt_next;
            match_reg  <= match_next;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDX_ENABLES: enables_reg <= cfg_data[3:0];
                CFG_IDX_COMPARE:
                begin
                    compare_reg <= cfg_data;
                    match_reg   <= (line_reg == cfg_data);
                end
                default: compare_reg <= compare_reg;
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_out_reg   <= mode_next;
            line_out_reg   <= line_next;
            match_out_reg  <= match_next;
            stat_out_reg   <= {enables_reg, match_next, mode_next};
            vbl_out_reg    <= vbl_req;
            lcdc_out_reg   <= lcdc_fire;
            render_out_reg <= render;
            swap_out_reg   <= swap;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lcd_mode       = mode_out_reg;
    assign current_line   = line_out_reg;
    assign line_match     = match_out_reg;
    assign stat_byte      = stat_out_reg;
    assign vblank_request = vbl_out_reg;
    assign lcdc_request   = lcdc_out_reg;
    assign render_strobe  = render_out_reg;
    assign swap_pulse     = swap_out_reg;

endmodule
`default_nettype wire

@@ src/lmtc_checker.sv @@
// Port-level checker for the LCD mode timing controller, with its bind.
`default_nettype none
`include "lcd_mode_timing_controller_defines.svh"
module lmtc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] lcd_mode,
    input wire logic [7:0] current_line,
    input wire logic       line_match,
    input wire logic [6:0] stat_byte,
    input wire logic       vblank_request,
    input wire logic       render_strobe,
    input wire logic       swap_pulse
);
    import lmtc_pkg::*;

    logic stat_ok;
    logic vbl_entry_ok;

    assign stat_ok      = (stat_byte[1:0] == lcd_mode) && (stat_byte[2] == line_match);
    assign vbl_entry_ok = (lcd_mode == MODE_FRAME_GAP) && (current_line == FIRST_VBLANK_LINE);

    // stalled result stays up
    `LMTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `LMTC_ASSERT_IMPLY(a_stat_fields, clk, rst_n, out_valid, stat_ok)
    `LMTC_ASSERT_IMPLY(a_render_hblank, clk, rst_n, out_valid && render_strobe, lcd_mode == MODE_LINE_GAP)
    `LMTC_ASSERT_IMPLY(a_vbl_entry, clk, rst_n, out_valid && vblank_request, vbl_entry_ok)
    `LMTC_ASSERT_IMPLY(a_swap_newframe, clk, rst_n, out_valid && swap_pulse, lcd_mode == MODE_OAM)

endmodule

bind lcd_mode_timing_controller lmtc_checker u_lmtc_checker (.*);
`default_nettype wire
